@@ hw/rtl/mpf_pkg.sv @@
// Shared types and constants for the Morse pattern flasher.
// No dependencies; used by morse_pattern_flasher and mpf_checker.
package mpf_pkg;

   localparam int MAX_ELEMENTS_DEF  = 8;
   localparam int WORD_GAP_DOTS_DEF = 7;

   localparam int CODE_W   = 8;
   localparam int COUNT_W  = 4;
   localparam int TICK_W   = 16;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 2;
   localparam int IDX_EXT_W = 5;   // holds any element index up to 31
   localparam int SAT_W     = 6;   // holds an element count up to 32

   localparam int REQ_DATA_W = 16; // code_word, element_count, word_break, active_high
   localparam int RSP_DATA_W = 8;  // line_level, busy_res, accepted

   localparam logic [7:0]  DOT_UNITS_RST  = 8'd1;
   localparam logic        SLOW_MODE_RST  = 1'b1;
   localparam logic [15:0] SLOW_GAP_RST   = 16'd12;
   localparam logic [15:0] TICK_MAX       = 16'hFFFF;
   localparam logic [15:0] DASH_DOTS      = 16'd3;
   localparam logic [15:0] LETTER_GAP_DOTS = 16'd3;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_MARK  = 2'd1,
      PH_GAP   = 2'd2,
      PH_SPACE = 2'd3
   } phase_type;

   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_START = 1'b1
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DOT_UNITS = 2'd0,
      CSR_SLOW_MODE = 2'd1,
      CSR_SLOW_GAP  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic accepted;
      logic busy_res;
      logic line_level;
   } result_type;

endpackage

@@ hw/rtl/morse_pattern_flasher.sv @@
// Morse pattern flasher top level: sequencer, configuration registers and
// a two-entry result buffer. Depends on mpf_pkg.
//
// Each request word (a tick or a start, selected by req_tuser) is processed
// in the cycle it is accepted and produces exactly one response word, so the
// block sustains one word per clock unless stalled. Responses sit in an output
// register backed by a skid register; req_tready drops only when both are full,
// i.e. after the response side has stalled for two words. Start words that arrive
// while a pattern or its trailing space is still running are answered with
// accepted = 0 and change nothing. Configuration writes take effect at once.
module morse_pattern_flasher #(
   parameter int MAX_ELEMENTS  = mpf_pkg::MAX_ELEMENTS_DEF,
   parameter int WORD_GAP_DOTS = mpf_pkg::WORD_GAP_DOTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] code_word, [11:8] element_count, [12] word_break, [13] active_high
   input  logic [mpf_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] opcode
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] line_level, [1] busy_res, [2] accepted
   output logic [mpf_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_we,
   input  logic [mpf_pkg::CSR_IDX_W-1:0]     csr_addr,
   input  logic [mpf_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int IDX_EXT_W_L = mpf_pkg::IDX_EXT_W;

   // configuration
   logic [7:0]  dot_units_ff;
   logic        slow_mode_ff;
   logic [15:0] slow_gap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_units_ff <= mpf_pkg::DOT_UNITS_RST;
         slow_mode_ff <= mpf_pkg::SLOW_MODE_RST;
         slow_gap_ff  <= mpf_pkg::SLOW_GAP_RST;
      end else if (csr_we) begin
         unique case (mpf_pkg::csr_index_type'(csr_addr))
            mpf_pkg::CSR_DOT_UNITS: dot_units_ff <= csr_wdata[7:0];
            mpf_pkg::CSR_SLOW_MODE: slow_mode_ff <= csr_wdata[0];
            mpf_pkg::CSR_SLOW_GAP:  slow_gap_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // request fields
   logic [mpf_pkg::CODE_W-1:0]  code_word;
   logic [mpf_pkg::COUNT_W-1:0] element_count;
   logic                        word_break;
   logic                        active_high;
   mpf_pkg::opcode_type         opcode;

   assign code_word     = req_tdata[7:0];
   assign element_count = req_tdata[11:8];
   assign word_break    = req_tdata[12];
   assign active_high   = req_tdata[13];
   assign opcode        = mpf_pkg::opcode_type'(req_tuser);

   // sequencer state
   mpf_pkg::phase_type          phase_ff, phase_in;
   logic [IDX_W-1:0]            index_ff, index_in;
   logic [mpf_pkg::TICK_W-1:0]  tick_ff, tick_in;
   logic [mpf_pkg::CODE_W-1:0]  code_ff, code_in;
   logic                        word_end_ff, word_end_in;
   logic                        polarity_ff, polarity_in;
   logic                        line_ff, line_in;

   logic                        req_fire;
   logic                        start_ok;
   logic [mpf_pkg::TICK_W-1:0]  tick_inc;
   logic [mpf_pkg::TICK_W-1:0]  dot_len;
   logic [mpf_pkg::TICK_W-1:0]  mark_len;
   logic [mpf_pkg::TICK_W-1:0]  space_len;
   logic [IDX_EXT_W_L-1:0]      index_ext;
   logic                        dash_bit;
   logic                        mark_done, gap_done, space_done;
   logic [mpf_pkg::SAT_W-1:0]   count_sat;

   assign req_fire = req_tvalid && req_tready;
   assign start_ok = (opcode == mpf_pkg::OP_START) && (phase_ff == mpf_pkg::PH_IDLE);

   assign tick_inc  = (tick_ff == mpf_pkg::TICK_MAX) ? tick_ff : tick_ff + 1'b1;
   assign dot_len   = (dot_units_ff == 8'd0) ? 16'd1 : 16'(dot_units_ff);
   assign index_ext = IDX_EXT_W_L'(index_ff);
   // elements above the code bits are dots
   assign dash_bit  = (index_ext < IDX_EXT_W_L'(mpf_pkg::CODE_W)) ?
                      code_ff[index_ext[2:0]] : 1'b0;
   assign mark_len  = dash_bit ? dot_len * mpf_pkg::DASH_DOTS : dot_len;

   always_comb begin
      if (slow_mode_ff) begin
         space_len = (slow_gap_ff == 16'd0) ? 16'd1 : slow_gap_ff;
      end else if (word_end_ff) begin
         space_len = dot_len * 16'(WORD_GAP_DOTS);
      end else begin
         space_len = dot_len * mpf_pkg::LETTER_GAP_DOTS;
      end
   end

   assign mark_done  = tick_inc >= mark_len;
   assign gap_done   = tick_inc >= dot_len;
   assign space_done = tick_inc >= space_len;

   assign count_sat = (mpf_pkg::SAT_W'(element_count) > mpf_pkg::SAT_W'(MAX_ELEMENTS)) ?
                      mpf_pkg::SAT_W'(MAX_ELEMENTS) : mpf_pkg::SAT_W'(element_count);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (opcode == mpf_pkg::OP_START) begin
         if (start_ok) begin
            phase_in = (count_sat == '0) ? mpf_pkg::PH_SPACE : mpf_pkg::PH_MARK;
         end
      end else begin
         unique case (phase_ff)
            mpf_pkg::PH_IDLE:  phase_in = mpf_pkg::PH_IDLE;
            mpf_pkg::PH_MARK: begin
               if (mark_done) begin
                  phase_in = (index_ff == '0) ? mpf_pkg::PH_SPACE : mpf_pkg::PH_GAP;
               end
            end
            mpf_pkg::PH_GAP: begin
               if (gap_done) phase_in = mpf_pkg::PH_MARK;
            end
            mpf_pkg::PH_SPACE: begin
               if (space_done) phase_in = mpf_pkg::PH_IDLE;
            end
            default: phase_in = mpf_pkg::PH_IDLE;
         endcase
      end
   end

   // datapath updates
   always_comb begin
      index_in    = index_ff;
      tick_in     = tick_ff;
      code_in     = code_ff;
      word_end_in = word_end_ff;
      polarity_in = polarity_ff;
      line_in     = line_ff;
      if (opcode == mpf_pkg::OP_START) begin
         if (start_ok) begin
            code_in     = code_word;
            word_end_in = word_break;
            polarity_in = active_high;
            tick_in     = '0;
            if (count_sat == '0) begin
               index_in = '0;
            end else begin
               index_in = IDX_W'(count_sat - 1'b1);
               line_in  = active_high;
            end
         end
      end else begin
         unique case (phase_ff)
            mpf_pkg::PH_IDLE: ;
            mpf_pkg::PH_MARK: begin
               tick_in = tick_inc;
               if (mark_done) begin
                  line_in = ~polarity_ff;
                  tick_in = '0;
               end
            end
            mpf_pkg::PH_GAP: begin
               tick_in = tick_inc;
               if (gap_done) begin
                  if (index_ff != '0) index_in = index_ff - 1'b1;
                  line_in = polarity_ff;
                  tick_in = '0;
               end
            end
            mpf_pkg::PH_SPACE: begin
               tick_in = space_done ? '0 : tick_inc;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= mpf_pkg::PH_IDLE;
         index_ff    <= '0;
         tick_ff     <= '0;
         code_ff     <= '0;
         word_end_ff <= 1'b0;
         polarity_ff <= 1'b0;
         line_ff     <= 1'b1;
      end else if (req_fire) begin
         phase_ff    <= phase_in;
         index_ff    <= index_in;
         tick_ff     <= tick_in;
         code_ff     <= code_in;
         word_end_ff <= word_end_in;
         polarity_ff <= polarity_in;
         line_ff     <= line_in;
      end
   end

   // result buffer: output register plus skid register
   mpf_pkg::result_type result_new, head_ff, skid_ff;
   logic                head_valid_ff, skid_valid_ff;
   logic                rsp_fire;

   assign result_new.line_level = line_in;
   assign result_new.busy_res   = (phase_in != mpf_pkg::PH_IDLE);
   assign result_new.accepted   = start_ok;

   assign rsp_fire   = head_valid_ff && rsp_tready;
   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = head_valid_ff;
   assign rsp_tdata  = {{(mpf_pkg::RSP_DATA_W - 3){1'b0}}, head_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!head_valid_ff || rsp_fire) begin
            // head is free next cycle: refill from skid first, else from new word
            if (skid_valid_ff) begin
               head_valid_ff <= 1'b1;
               skid_valid_ff <= req_fire;
            end else begin
               head_valid_ff <= req_fire;
            end
         end else if (req_fire) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!head_valid_ff || rsp_fire) begin
         if (skid_valid_ff) begin
            head_ff <= skid_ff;
            if (req_fire) skid_ff <= result_new;
         end else if (req_fire) begin
            head_ff <= result_new;
         end
      end else if (req_fire) begin
         skid_ff <= result_new;
      end
   end

endmodule

@@ hw/rtl/mpf_checker.sv @@
// Port-level checks for the Morse pattern flasher, bound to the top level.
// Depends on mpf_pkg for the response width.
module mpf_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [mpf_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // a taken start always leaves the block busy
   ap_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[2] || rsp_tdata[1]))
      else $error("accepted start reported while not busy");

   // input stalls only when a response is already waiting
   ap_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled with no pending response");

   // a word taken on an empty output shows up in the next cycle
   ap_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid) |=> rsp_tvalid)
      else $error("response missing after accepted request");

   // stalled response holds
   ap_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind morse_pattern_flasher mpf_checker u_mpf_checker (.*);
